// ===== hdl/lfu_pkg.sv =====
// Shared types for the LFU cache table.
package lfu_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Update command broadcast from the controller to every cell.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOUCH,
    OP_REPLACE,
    OP_INSERT
  } op_t;

endpackage

// ===== hdl/lfu_cell.sv =====
// One entry of the cache table with its scan stage and update logic.
module lfu_cell import lfu_pkg::*; #(
  parameter int COUNT_WIDTH = 16,
  parameter int RANK_WIDTH  = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  // scan token passed along the row
  input  logic                   scan_in,
  output logic                   scan_out,
  input  logic [31:0]            req_key,
  // running search state from the previous cell
  input  logic                   hit_in,
  input  logic [31:0]            hdata_in,
  input  logic [RANK_WIDTH-1:0]  hrank_in,
  input  logic                   vic_in,
  input  logic [COUNT_WIDTH-1:0] vcnt_in,
  input  logic [RANK_WIDTH-1:0]  vrank_in,
  input  logic                   free_in,
  output logic                   hit_out,
  output logic [31:0]            hdata_out,
  output logic [RANK_WIDTH-1:0]  hrank_out,
  output logic                   vic_out,
  output logic [COUNT_WIDTH-1:0] vcnt_out,
  output logic [RANK_WIDTH-1:0]  vrank_out,
  output logic                   free_out,
  // update broadcast
  input  op_t                    op,
  input  logic [RANK_WIDTH-1:0]  tgt_rank,
  input  logic [31:0]            new_key,
  input  logic [31:0]            new_data,
  output logic                   sel
);

  logic                   valid;
  logic [31:0]            key;
  logic [31:0]            data;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [RANK_WIDTH-1:0]  rank;
  logic                   match;
  logic                   hit_sel, vic_sel, free_sel;
  logic                   better;
  logic                   hit_next;
  logic [31:0]            hdata_next;
  logic [RANK_WIDTH-1:0]  hrank_next;
  logic                   vic_next;
  logic [COUNT_WIDTH-1:0] vcnt_next;
  logic [RANK_WIDTH-1:0]  vrank_next;
  logic                   free_next;

  assign match  = valid && key == req_key;
  assign better = !vic_in || cnt < vcnt_in || (cnt == vcnt_in && rank > vrank_in);

  always_comb begin
    hit_next   = hit_in;
    hdata_next = hdata_in;
    hrank_next = hrank_in;
    vic_next   = vic_in;
    vcnt_next  = vcnt_in;
    vrank_next = vrank_in;
    free_next  = free_in;
    if (scan_in && match && !hit_in) begin
      hit_next   = 1'b1;
      hdata_next = data;
      hrank_next = rank;
    end
    if (scan_in && valid && better) begin
      vic_next   = 1'b1;
      vcnt_next  = cnt;
      vrank_next = rank;
    end
    if (scan_in && !valid) free_next = 1'b1;
  end

  // search state moves on to the next cell together with the token
  always_ff @(posedge clk) begin
    scan_out  <= rst ? 1'b0 : scan_in;
    hit_out   <= hit_next;
    hdata_out <= hdata_next;
    hrank_out <= hrank_next;
    vic_out   <= vic_next;
    vcnt_out  <= vcnt_next;
    vrank_out <= vrank_next;
    free_out  <= free_next;
  end

  // Cell keeps its own selection flags from the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_sel  <= 1'b0;
      vic_sel  <= 1'b0;
      free_sel <= 1'b0;
    end else if (scan_in) begin
      hit_sel  <= match;
      // a later better victim does not clear this flag; the controller picks by rank
      vic_sel  <= valid && better;
      free_sel <= !valid && !free_in;
    end
  end

  always_comb begin
    unique case (op)
      OP_TOUCH:   sel = hit_sel;
      OP_REPLACE: sel = valid && vic_sel && rank == tgt_rank;
      OP_INSERT:  sel = free_sel;
      default:    sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op) inside
        OP_TOUCH, OP_REPLACE: begin
          if (sel) begin
            rank <= '0;
            if (op == OP_REPLACE) begin
              key  <= new_key;
              data <= new_data;
              cnt  <= COUNT_WIDTH'(1);
            end else begin
              data <= new_data;
              if (cnt != '1) cnt <= cnt + COUNT_WIDTH'(1);
            end
          end else if (valid && rank < tgt_rank) begin
            rank <= rank + RANK_WIDTH'(1);
          end
        end
        OP_INSERT: begin
          if (sel) begin
            valid <= 1'b1;
            key   <= new_key;
            data  <= new_data;
            cnt   <= COUNT_WIDTH'(1);
            rank  <= '0;
          end else if (valid) begin
            rank <= rank + RANK_WIDTH'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/lfu_cache_table.sv =====
// Top level of the LFU cache table: controller and row of entry cells.
// Channel  Signals                              Dir
// request  req_valid req_ready action key value in
// result   rsp_valid rsp_ready hit read_value   out
// config   cfg_valid cfg_ready cfg_data         in
// A request runs in steps: the token walks the row one cell per cycle, then
// the update state, then the result is shown until it is taken, and the
// controller returns to idle before the next request is taken.
// Synchronous reset clears all valid bits and occupancy, and sets active_capacity=16.
// The result register holds until taken; the next request is accepted once
// the result is out of the way. Config is taken at any time.
module lfu_cache_table import lfu_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        action,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        hit,
  output logic [31:0] read_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  state_t st, st_next;
  logic [4:0] active_capacity;
  logic [OW-1:0] occupancy;
  logic req_act;
  logic [31:0] req_key, req_val;

  logic [CAPACITY:0] scan;
  logic [CAPACITY:0] c_hit, c_vic, c_free;
  logic [31:0] c_hdata [CAPACITY+1];
  logic [RW-1:0] c_hrank [CAPACITY+1];
  logic [COUNT_WIDTH-1:0] c_vcnt [CAPACITY+1];
  logic [RW-1:0] c_vrank [CAPACITY+1];
  logic [CAPACITY-1:0] sel;

  logic r_hit, r_vic, r_free;
  logic [31:0] r_hdata;
  logic [RW-1:0] r_hrank, r_vrank;
  op_t op;
  logic [RW-1:0] tgt_rank;
  logic [5:0] cap_eff;
  logic full;

  assign cfg_ready = 1'b1;
  assign req_ready = st == ST_IDLE;

  assign c_hit[0]  = 1'b0;
  assign c_vic[0]  = 1'b0;
  assign c_free[0] = 1'b0;
  assign c_hdata[0] = '0;
  assign c_hrank[0] = '0;
  assign c_vcnt[0]  = '0;
  assign c_vrank[0] = '0;
  assign scan[0] = req_valid && req_ready;

  // Token and running search state move one cell per cycle; cell 0 scans
  // in the accept cycle straight from the key port.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lfu_cell #(.COUNT_WIDTH(COUNT_WIDTH), .RANK_WIDTH(RW)) u_cell (
      .clk, .rst,
      .scan_in(scan[i]), .scan_out(scan[i+1]),
      .req_key(i == 0 ? key : req_key),
      .hit_in(c_hit[i]), .hdata_in(c_hdata[i]), .hrank_in(c_hrank[i]),
      .vic_in(c_vic[i]), .vcnt_in(c_vcnt[i]), .vrank_in(c_vrank[i]),
      .free_in(c_free[i]),
      .hit_out(c_hit[i+1]), .hdata_out(c_hdata[i+1]), .hrank_out(c_hrank[i+1]),
      .vic_out(c_vic[i+1]), .vcnt_out(c_vcnt[i+1]), .vrank_out(c_vrank[i+1]),
      .free_out(c_free[i+1]),
      .op, .tgt_rank, .new_key(req_key),
      .new_data(req_act == ACT_PUT ? req_val : r_hdata), .sel(sel[i])
    );
  end

  always_ff @(posedge clk) begin
    if (scan[0]) begin
      req_act <= action;
      req_key <= key;
      req_val <= value;
    end
    if (scan[CAPACITY]) begin
      r_hit   <= c_hit[CAPACITY];
      r_hdata <= c_hdata[CAPACITY];
      r_hrank <= c_hrank[CAPACITY];
      r_vic   <= c_vic[CAPACITY];
      r_vrank <= c_vrank[CAPACITY];
      r_free  <= c_free[CAPACITY];
    end
  end

  assign cap_eff = (active_capacity > 5'(CAPACITY > 31 ? 31 : CAPACITY)) &&
                   CAPACITY < 32 ? 6'(CAPACITY) : {1'b0, active_capacity};
  assign full = 6'(occupancy) >= cap_eff;

  always_comb begin
    op = OP_NONE;
    tgt_rank = '1;
    if (st == ST_UPDATE) begin
      if (r_hit) begin
        if (req_act == ACT_GET || cap_eff != '0) begin
          op = OP_TOUCH;
          tgt_rank = r_hrank;
        end
      end else if (req_act == ACT_PUT && cap_eff != '0) begin
        if (full && r_vic) begin
          op = OP_REPLACE;
          tgt_rank = r_vrank;
        end else if (!full && r_free) begin
          op = OP_INSERT;
        end
      end
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:   if (req_valid) st_next = ST_SCAN;
      ST_SCAN:   if (scan[CAPACITY]) st_next = ST_UPDATE;
      ST_UPDATE: st_next = ST_DONE;
      ST_DONE:   if (rsp_ready) st_next = ST_IDLE;
      default:   st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      active_capacity <= 5'd16;
      occupancy <= '0;
    end else begin
      st <= st_next;
      if (cfg_valid) active_capacity <= cfg_data;
      if (op == OP_INSERT) occupancy <= occupancy + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_UPDATE) begin
      hit <= r_hit;
      read_value <= (r_hit && req_act == ACT_GET) ? r_hdata : 32'd0;
    end
  end

  assign rsp_valid = st == ST_DONE;

endmodule
